@@ rtl/gdc_pkg.sv @@
// Package with the shared constants, lookup functions and pipeline stage types of the converter.
`default_nettype none

package gdc_pkg;

  // Field widths of the request and response items.
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int CountW = 22;

  // Lengths of the Gregorian cycles in days.
  localparam int unsigned CycDays400 = 146097;
  localparam int unsigned CycDays100 = 36524;
  localparam int unsigned CycDays4   = 1461;
  localparam int unsigned YearDays   = 365;

  // Reciprocals for division by constants. The year reciprocal is exact for any 14-bit value;
  // the cycle reciprocals may undershoot by one and are corrected afterwards.
  localparam int unsigned Rec100    = 5243;
  localparam int unsigned Rec100Sh  = 19;
  localparam int unsigned Rec400Sh  = 24;
  localparam int unsigned Rec400    = (1 << Rec400Sh) / CycDays400;
  localparam int unsigned Rec4Sh    = 16;
  localparam int unsigned Rec4      = (1 << Rec4Sh) / CycDays4;

  // Days before the first day of a month in a common year.
  function automatic logic [8:0] cum_days(input logic [MonthW-1:0] month);
    logic [8:0] res;
    case (month)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Length of a month in a common year; zero for a month code that means nothing.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month);
    logic [DayW-1:0] res;
    case (month) inside
      4'd2:                     res = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  res = 5'd30;
      [4'd1:4'd12]:             res = 5'd31;
      default:                  res = 5'd0;
    endcase
    return res;
  endfunction

  typedef struct packed {
    logic              req;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [22:0]       yr_days;
    logic [26:0]       year_prod;
    logic [26:0]       prev_prod;
    logic [CountW-1:0] count;
    logic [28:0]       cyc_prod;
    logic              cnt_err;
  } s1_t;

  typedef struct packed {
    logic              req;
    logic [22:0]       yr_days;
    logic [8:0]        mon_days;
    logic [DayW-1:0]   day;
    logic              date_err;
    logic [4:0]        n400;
    logic [18:0]       rem;
    logic              cnt_err;
  } s2_t;

  typedef struct packed {
    logic              req;
    logic [CountW-1:0] dcnt;
    logic              date_err;
    logic              cnt_err;
    logic [4:0]        n400;
    logic [17:0]       rem;
  } s3_t;

  typedef struct packed {
    logic              req;
    logic [CountW-1:0] dcnt;
    logic              date_err;
    logic              cnt_err;
    logic [4:0]        n400;
    logic [1:0]        n100;
    logic [15:0]       rem;
  } s4_t;

  typedef struct packed {
    logic              req;
    logic [CountW-1:0] dcnt;
    logic              date_err;
    logic              cnt_err;
    logic [4:0]        n400;
    logic [1:0]        n100;
    logic [15:0]       rem;
    logic [21:0]       cyc_prod;
  } s5_t;

  typedef struct packed {
    logic              req;
    logic [CountW-1:0] dcnt;
    logic              date_err;
    logic              cnt_err;
    logic [4:0]        n400;
    logic [1:0]        n100;
    logic [4:0]        n4;
    logic [11:0]       rem;
  } s6_t;

  typedef struct packed {
    logic              req;
    logic [CountW-1:0] dcnt;
    logic              date_err;
    logic              cnt_err;
    logic [4:0]        n400;
    logic [1:0]        n100;
    logic [4:0]        n4;
    logic [10:0]       rem;
  } s7_t;

  typedef struct packed {
    logic              req;
    logic [CountW-1:0] dcnt;
    logic              date_err;
    logic              cnt_err;
    logic [YearW-1:0]  year;
    logic              leap;
    logic [8:0]        doy;
  } s8_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [CountW-1:0] count;
    logic              err;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/gdc_if.sv @@
// Request and response channel interfaces of the converter.
`default_nettype none

interface gdc_req_if import gdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [YearW-1:0]  in_year;
  logic [MonthW-1:0] in_month;
  logic [DayW-1:0]   in_day;
  logic [CountW-1:0] in_day_count;

  modport source (output valid, req_type, in_year, in_month, in_day, in_day_count,
                  input ready);
  modport sink   (input valid, req_type, in_year, in_month, in_day, in_day_count,
                  output ready);
endinterface

interface gdc_rsp_if import gdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  out_year;
  logic [MonthW-1:0] out_month;
  logic [DayW-1:0]   out_day;
  logic [CountW-1:0] out_day_count;
  logic              range_error;

  modport source (output valid, out_year, out_month, out_day, out_day_count, range_error,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_day, out_day_count, range_error,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/gregorian_date_day_count_converter.sv @@
// The nine-stage pipeline carries each request to its response; throughput is one request
// per cycle while responses are taken. The count-to-date path splits the 400/100/4/1-year
// decomposition over reciprocal multiply, subtract and correct stages, one step per stage.
// Each stage holds its item while the next cannot load, so a stalled response holds no bubble.
// Reset: rst_ni is asynchronous and active low and clears only the stage valid bits.
// No stored state besides the pipeline, so there is no clearing pass after reset.
`default_nettype none

module gregorian_date_day_count_converter import gdc_pkg::*; #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gdc_req_if.sink    in_i,
  gdc_rsp_if.source  out_o
);

  localparam int unsigned NumStages  = 9;
  localparam int unsigned CountLimit = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                       + MAX_YEAR / 400;

  logic [NumStages-1:0] valid_q, valid_d, adv;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  s5_t  s5_d, s5_q;
  s6_t  s6_d, s6_q;
  s7_t  s7_d, s7_q;
  s8_t  s8_d, s8_q;
  res_t res_d, res_q;

  // A stage may load when it is empty or when its item moves on in the same cycle.
  assign adv[NumStages-1] = !valid_q[NumStages-1] || out_o.ready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  assign in_i.ready = adv[0];
  assign valid_d = (valid_q & ~adv) | ({valid_q[NumStages-2:0], in_i.valid} & adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) s1_q <= s1_d;
    if (adv[1]) s2_q <= s2_d;
    if (adv[2]) s3_q <= s3_d;
    if (adv[3]) s4_q <= s4_d;
    if (adv[4]) s5_q <= s5_d;
    if (adv[5]) s6_q <= s6_d;
    if (adv[6]) s7_q <= s7_d;
    if (adv[7]) s8_q <= s8_d;
    if (adv[8]) res_q <= res_d;
  end

  // Stage 1: constant products for the year sums and the 400-year cycle estimate; count range check.
  logic [YearW-1:0] in_prev;
  assign in_prev = in_i.in_year - 14'd1;

  always_comb begin
    s1_d.req       = in_i.req_type;
    s1_d.year      = in_i.in_year;
    s1_d.month     = in_i.in_month;
    s1_d.day       = in_i.in_day;
    s1_d.yr_days   = 23'(in_prev) * 23'(YearDays);
    s1_d.year_prod = 27'(in_i.in_year) * 27'(Rec100);
    s1_d.prev_prod = 27'(in_prev) * 27'(Rec100);
    s1_d.count     = in_i.in_day_count;
    s1_d.cyc_prod  = 29'(in_i.in_day_count) * 29'(Rec400);
    s1_d.cnt_err   = 32'(in_i.in_day_count) >= CountLimit;
  end

  // Stage 2: leap rule, date check, days before the year and the month; first 400-year remainder.
  logic [YearW-1:0]  s2_prev;
  logic [7:0]        year_cent, prev_cent;
  logic              s2_is_cent, s2_leap;
  logic [DayW-1:0]   s2_mlen;
  logic [4:0]        s2_n400;
  logic [CountW-1:0] s2_rem;

  always_comb begin
    s2_prev    = s1_q.year - 14'd1;
    year_cent  = s1_q.year_prod[26:19];
    prev_cent  = s1_q.prev_prod[26:19];
    s2_is_cent = 15'(s1_q.year) == 15'(year_cent) * 15'd100;
    s2_leap    = (s1_q.year[1:0] == 2'b00) && (!s2_is_cent || year_cent[1:0] == 2'b00);
    s2_mlen    = month_len(s1_q.month) + 5'(s2_leap && s1_q.month == 4'd2);
    s2_n400    = s1_q.cyc_prod[28:24];
    s2_rem     = s1_q.count - 22'(s2_n400) * 22'(CycDays400);

    s2_d.req      = s1_q.req;
    s2_d.yr_days  = s1_q.yr_days + 23'(s2_prev[13:2]) - 23'(prev_cent) + 23'(prev_cent[7:2]);
    s2_d.mon_days = cum_days(s1_q.month) + 9'(s2_leap && s1_q.month > 4'd2);
    s2_d.day      = s1_q.day;
    s2_d.date_err = (s1_q.year == 14'd0) || (32'(s1_q.year) > MAX_YEAR) ||
                    (s1_q.month == 4'd0) || (s1_q.month > 4'd12) ||
                    (s1_q.day == 5'd0) || (s1_q.day > s2_mlen);
    s2_d.n400     = s2_n400;
    s2_d.rem      = s2_rem[18:0];
    s2_d.cnt_err  = s1_q.cnt_err;
  end

  // Stage 3: the day count of a date is complete; the 400-year quotient is corrected.
  logic [22:0] s3_sum;
  logic [18:0] s3_rem;

  always_comb begin
    s3_sum = s2_q.yr_days + 23'(s2_q.mon_days) + 23'(s2_q.day) - 23'd1;
    s3_rem = s2_q.rem;

    s3_d.req      = s2_q.req;
    s3_d.dcnt     = s2_q.date_err ? '0 : s3_sum[CountW-1:0];
    s3_d.date_err = s2_q.date_err;
    s3_d.cnt_err  = s2_q.cnt_err;
    s3_d.n400     = s2_q.n400;
    if (s2_q.rem >= 19'(CycDays400)) begin
      s3_d.n400 = s2_q.n400 + 5'd1;
      s3_rem    = s2_q.rem - 19'(CycDays400);
    end
    s3_d.rem = s3_rem[17:0];
  end

  // Stage 4: century within the 400-year cycle; the last century is one day longer.
  logic [17:0] s4_rem;

  always_comb begin
    s4_d.req      = s3_q.req;
    s4_d.dcnt     = s3_q.dcnt;
    s4_d.date_err = s3_q.date_err;
    s4_d.cnt_err  = s3_q.cnt_err;
    s4_d.n400     = s3_q.n400;
    if (s3_q.rem >= 18'(3 * CycDays100)) begin
      s4_d.n100 = 2'd3;
      s4_rem    = s3_q.rem - 18'(3 * CycDays100);
    end else if (s3_q.rem >= 18'(2 * CycDays100)) begin
      s4_d.n100 = 2'd2;
      s4_rem    = s3_q.rem - 18'(2 * CycDays100);
    end else if (s3_q.rem >= 18'(CycDays100)) begin
      s4_d.n100 = 2'd1;
      s4_rem    = s3_q.rem - 18'(CycDays100);
    end else begin
      s4_d.n100 = 2'd0;
      s4_rem    = s3_q.rem;
    end
    s4_d.rem = s4_rem[15:0];
  end

  // Stage 5: estimate of the four-year cycle within the century.
  always_comb begin
    s5_d.req      = s4_q.req;
    s5_d.dcnt     = s4_q.dcnt;
    s5_d.date_err = s4_q.date_err;
    s5_d.cnt_err  = s4_q.cnt_err;
    s5_d.n400     = s4_q.n400;
    s5_d.n100     = s4_q.n100;
    s5_d.rem      = s4_q.rem;
    s5_d.cyc_prod = 22'(s4_q.rem) * 22'(Rec4);
  end

  // Stage 6: remainder after the estimated four-year cycles.
  logic [4:0]  s6_n4;
  logic [15:0] s6_rem;

  always_comb begin
    s6_n4  = s5_q.cyc_prod[20:16];
    s6_rem = s5_q.rem - 16'(s6_n4) * 16'(CycDays4);

    s6_d.req      = s5_q.req;
    s6_d.dcnt     = s5_q.dcnt;
    s6_d.date_err = s5_q.date_err;
    s6_d.cnt_err  = s5_q.cnt_err;
    s6_d.n400     = s5_q.n400;
    s6_d.n100     = s5_q.n100;
    s6_d.n4       = s6_n4;
    s6_d.rem      = s6_rem[11:0];
  end

  // Stage 7: correction of the four-year quotient.
  logic [11:0] s7_rem;

  always_comb begin
    s7_rem = s6_q.rem;

    s7_d.req      = s6_q.req;
    s7_d.dcnt     = s6_q.dcnt;
    s7_d.date_err = s6_q.date_err;
    s7_d.cnt_err  = s6_q.cnt_err;
    s7_d.n400     = s6_q.n400;
    s7_d.n100     = s6_q.n100;
    s7_d.n4       = s6_q.n4;
    if (s6_q.rem >= 12'(CycDays4)) begin
      s7_d.n4 = s6_q.n4 + 5'd1;
      s7_rem  = s6_q.rem - 12'(CycDays4);
    end
    s7_d.rem = s7_rem[10:0];
  end

  // Stage 8: year within the four-year cycle, day of the year, year number and leap flag.
  // The year is a leap year when it is the last of its four-year cycle, unless it closes a
  // century that does not also close the 400-year cycle.
  logic [1:0]  s8_n1;
  logic [10:0] s8_doy;

  always_comb begin
    if (s7_q.rem >= 11'(3 * YearDays)) begin
      s8_n1 = 2'd3;
    end else if (s7_q.rem >= 11'(2 * YearDays)) begin
      s8_n1 = 2'd2;
    end else if (s7_q.rem >= 11'(YearDays)) begin
      s8_n1 = 2'd1;
    end else begin
      s8_n1 = 2'd0;
    end
    s8_doy = s7_q.rem - 11'(s8_n1) * 11'(YearDays);

    s8_d.req      = s7_q.req;
    s8_d.dcnt     = s7_q.dcnt;
    s8_d.date_err = s7_q.date_err;
    s8_d.cnt_err  = s7_q.cnt_err;
    s8_d.year     = 14'(s7_q.n400) * 14'd400 + 14'(s7_q.n100) * 14'd100 +
                    14'({s7_q.n4, 2'b00}) + 14'(s8_n1) + 14'd1;
    s8_d.leap     = (s8_n1 == 2'd3) && (s7_q.n4 != 5'd24 || s7_q.n100 == 2'd3);
    s8_d.doy      = s8_doy[8:0];
  end

  // Stage 9: month search over the cumulative month table and the response select.
  logic [MonthW-1:0] s9_month;
  logic [8:0]        s9_day;

  always_comb begin
    s9_month = 4'd1;
    for (int unsigned i = 2; i <= 12; i++) begin
      if (s8_q.doy >= cum_days(4'(i)) + 9'(s8_q.leap && i > 2)) begin
        s9_month = 4'(i);
      end
    end
    s9_day = s8_q.doy - (cum_days(s9_month) + 9'(s8_q.leap && s9_month > 4'd2)) + 9'd1;

    res_d = '0;
    if (!s8_q.req) begin
      res_d.count = s8_q.dcnt;
      res_d.err   = s8_q.date_err;
    end else if (s8_q.cnt_err) begin
      res_d.err = 1'b1;
    end else begin
      res_d.year  = s8_q.year;
      res_d.month = s9_month;
      res_d.day   = s9_day[DayW-1:0];
    end
  end

  assign out_o.valid         = valid_q[NumStages-1];
  assign out_o.out_year      = res_q.year;
  assign out_o.out_month     = res_q.month;
  assign out_o.out_day       = res_q.day;
  assign out_o.out_day_count = res_q.count;
  assign out_o.range_error   = res_q.err;

endmodule

`default_nettype wire

@@ rtl/gdc_checker.sv @@
// Port-level checker of the converter and the bind that attaches it to the top level.
`default_nettype none

module gdc_checker import gdc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [YearW-1:0]  out_year_i,
  input logic [MonthW-1:0] out_month_i,
  input logic [DayW-1:0]   out_day_i,
  input logic [CountW-1:0] out_day_count_i,
  input logic              range_error_i
);

  // A response that is not taken stays, unchanged, until its transfer.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_year_i) &&
      $stable(out_month_i) && $stable(out_day_i) && $stable(out_day_count_i) &&
      $stable(range_error_i))
    else $error("response changed before its transfer");

  // With the response side ready, every pipeline stage can move, so requests are taken.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("request side stalled while the response side is ready");

  // An error response carries no date and no count.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && range_error_i |-> out_year_i == '0 && out_month_i == '0 &&
      out_day_i == '0 && out_day_count_i == '0)
    else $error("error response with non-zero fields");

  // A good response is either a day count alone or a complete date alone.
  a_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !range_error_i |->
      (out_year_i == '0 && out_month_i == '0 && out_day_i == '0) ||
      (out_year_i != '0 && out_month_i >= 4'd1 && out_month_i <= 4'd12 &&
       out_day_i != '0 && out_day_count_i == '0))
    else $error("response mixes a date and a day count");

  // A request is refused only while a response waits to be taken.
  a_req_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("request refused with no response waiting");

endmodule

bind gregorian_date_day_count_converter gdc_checker u_gdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_year_i      (out_o.out_year),
  .out_month_i     (out_o.out_month),
  .out_day_i       (out_o.out_day),
  .out_day_count_i (out_o.out_day_count),
  .range_error_i   (out_o.range_error)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the Gregorian date and day-count converter.
module tb_top;
  import gdc_pkg::*;

  localparam int unsigned MaxYear = 9999;
  // First count past the last day of the largest supported year.
  localparam int unsigned CountLimit = MaxYear * 365 + MaxYear / 4 - MaxYear / 100
                                     + MaxYear / 400;
  localparam int unsigned RandomItems = 1350;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainSlack  = 30;
  localparam int unsigned ChokeAt     = 500;
  localparam int unsigned PauseAt     = 900;

  localparam logic DateToCount = 1'b0;
  localparam logic CountToDate = 1'b1;

  typedef enum int unsigned { RX_STREAM, RX_RANDOM, RX_PERIODIC } rx_mode_e;

  typedef struct packed {
    logic              kind;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [CountW-1:0] count;
  } conv_req_t;

  // A fixed outcome typed into the directed rows; otherwise the predictor decides.
  typedef struct packed {
    logic fixed;
    res_t res;
  } pinned_t;

  typedef struct packed {
    conv_req_t rq;
    pinned_t   pin;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  gdc_req_if req_ch ();
  gdc_rsp_if rsp_ch ();

  gregorian_date_day_count_converter #(
    .MAX_YEAR(MaxYear)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_ch),
    .out_o (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_row_t stim_rows[$];
  pinned_t   pinned_q[$];
  res_t      dates_due[$];
  int unsigned transfers_in  = 0;
  int unsigned transfers_out = 0;
  int unsigned mismatches    = 0;
  int unsigned choke_reqs    = 0;
  int unsigned burst_left    = 0;

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Days from the first day of year one to the first day of year y.
  function automatic int unsigned year_start(input int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic res_t convert(input conv_req_t rq);
    res_t        r;
    int unsigned y, m, d, c;
    r = '0;
    if (rq.kind == DateToCount) begin
      y = rq.year;
      m = rq.month;
      d = rq.day;
      if (y < 1 || y > MaxYear || m < 1 || m > 12 || d < 1 || d > month_length(y, m)) begin
        r.err = 1'b1;
      end else begin
        c = year_start(y) + d - 1;
        for (int unsigned k = 1; k < m; k++) c += month_length(y, k);
        r.count = CountW'(c);
      end
    end else begin
      c = rq.count;
      if (c >= CountLimit) begin
        r.err = 1'b1;
      end else begin
        // Estimate the year from the mean year length, then settle it exactly.
        y = (c * 400) / 146097 + 1;
        while (year_start(y + 1) <= c) y++;
        while (year_start(y) > c) y--;
        c -= year_start(y);
        m = 1;
        while (c >= month_length(y, m)) begin
          c -= month_length(y, m);
          m++;
        end
        r.year  = YearW'(y);
        r.month = MonthW'(m);
        r.day   = DayW'(c + 1);
      end
    end
    return r;
  endfunction

  function automatic res_t outcome(input int unsigned y, input int unsigned m,
                                   input int unsigned d, input int unsigned c,
                                   input logic e);
    res_t r;
    r.year  = YearW'(y);
    r.month = MonthW'(m);
    r.day   = DayW'(d);
    r.count = CountW'(c);
    r.err   = e;
    return r;
  endfunction

  task automatic add_row(input logic kind, input int unsigned y, input int unsigned m,
                         input int unsigned d, input int unsigned c,
                         input logic fixed, input res_t res);
    stim_row_t row;
    row.rq.kind    = kind;
    row.rq.year    = YearW'(y);
    row.rq.month   = MonthW'(m);
    row.rq.day     = DayW'(d);
    row.rq.count   = CountW'(c);
    row.pin.fixed  = fixed;
    row.pin.res    = res;
    stim_rows.push_back(row);
  endtask

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 8);
      1:       return $urandom_range(MaxYear - 7, MaxYear);
      2:       return $urandom_range(1, 99) * 100;
      3:       return $urandom_range(1, 24) * 400;
      default: return $urandom_range(1, MaxYear);
    endcase
  endfunction

  function automatic int unsigned pick_count();
    int unsigned base;
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 800);
      1:       return CountLimit - 1 - $urandom_range(0, 800);
      2, 3: begin
        // Land near the seams of the 400, 100, 4 and 1-year cycles.
        base = $urandom_range(0, 24) * 146097 + $urandom_range(1, 3) * 36524
             + $urandom_range(0, 24) * 1461 + $urandom_range(0, 3) * 365;
        return base + $urandom_range(0, 4) - 2;
      end
      default: return $urandom_range(0, CountLimit - 1);
    endcase
  endfunction

  function automatic conv_req_t random_request();
    conv_req_t   rq;
    int unsigned y, m, pick;
    rq.kind  = 1'($urandom);
    rq.year  = YearW'($urandom);
    rq.month = MonthW'($urandom);
    rq.day   = DayW'($urandom);
    rq.count = CountW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      y = pick_year();
      m = $urandom_range(1, 12);
      rq.kind  = DateToCount;
      rq.year  = YearW'(y);
      rq.month = MonthW'(m);
      rq.day   = DayW'(($urandom_range(0, 3) == 0) ? month_length(y, m)
                                                   : $urandom_range(1, month_length(y, m)));
    end else if (pick < 75) begin
      rq.kind  = CountToDate;
      rq.count = CountW'(pick_count());
    end else if (pick < 85) begin
      // One day past the end of the month.
      y = pick_year();
      m = $urandom_range(1, 12);
      rq.kind  = DateToCount;
      rq.year  = YearW'(y);
      rq.month = MonthW'(m);
      rq.day   = DayW'(month_length(y, m) + 1);
    end
    return rq;
  endfunction

  task automatic idle(input int unsigned cycles);
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= 1'($urandom);
    req_ch.in_year      <= YearW'($urandom);
    req_ch.in_month     <= MonthW'($urandom);
    req_ch.in_day       <= DayW'($urandom);
    req_ch.in_day_count <= CountW'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Opens a gap before each new burst; some bursts are long stretches without gaps.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 40);
      idle($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  task automatic offer(input conv_req_t rq, input pinned_t pin);
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rq.kind;
    req_ch.in_year      <= rq.year;
    req_ch.in_month     <= rq.month;
    req_ch.in_day       <= rq.day;
    req_ch.in_day_count <= rq.count;
    pinned_q.push_back(pin);
    do @(posedge clk); while (!req_ch.ready);
    transfers_in++;
  endtask

  task automatic drain();
    idle(1);
    while (transfers_out != transfers_in) @(posedge clk);
  endtask

  task automatic report(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want y=%0d m=%0d d=%0d cnt=%0d err=%0b, got y=%0d m=%0d d=%0d cnt=%0d err=%0b",
               what, want.year, want.month, want.day, want.count, want.err,
               got.year, got.month, got.day, got.count, got.err);
    end
  endtask

  // Predicts on every request transfer and checks every response transfer.
  always @(posedge clk) begin : watch
    conv_req_t rq;
    pinned_t   pin;
    res_t      got, want;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        rq.kind  = req_ch.req_type;
        rq.year  = req_ch.in_year;
        rq.month = req_ch.in_month;
        rq.day   = req_ch.in_day;
        rq.count = req_ch.in_day_count;
        pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
        dates_due.push_back(pin.fixed ? pin.res : convert(rq));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.year  = rsp_ch.out_year;
        got.month = rsp_ch.out_month;
        got.day   = rsp_ch.out_day;
        got.count = rsp_ch.out_day_count;
        got.err   = rsp_ch.range_error;
        transfers_out++;
        if (dates_due.size() == 0) begin
          report("unexpected transfer", '0, got);
        end else begin
          want = dates_due.pop_front();
          if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
              got.count !== want.count || got.err !== want.err) begin
            report("mismatch", want, got);
          end
        end
      end
    end
  end

  // Response side: segments of free flow, random stalls and a periodic pattern, plus
  // one long hold-off on request so that the pipeline backs up into the input.
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned seg_left, period, phase, hold_left, chokes_seen;
    mode = RX_STREAM;
    seg_left = 0;
    period = 2;
    phase = 0;
    hold_left = 0;
    chokes_seen = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (choke_reqs != chokes_seen) begin
        chokes_seen = choke_reqs;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 200);
          mode = rx_mode_e'($urandom_range(0, 2));
          period = $urandom_range(2, 7);
        end
        seg_left--;
        phase++;
        case (mode)
          RX_STREAM: rsp_ch.ready <= 1'b1;
          RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   rsp_ch.ready <= ((phase % period) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    pinned_t     loose;
    res_t        bad;
    int unsigned i;
    loose = '0;
    bad = outcome(0, 0, 0, 0, 1'b1);
    rst_n <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= DateToCount;
    req_ch.in_year      <= '0;
    req_ch.in_month     <= '0;
    req_ch.in_day       <= '0;
    req_ch.in_day_count <= '0;

    add_row(DateToCount, 1, 1, 1, 0, 1'b1, outcome(0, 0, 0, 0, 1'b0));
    add_row(DateToCount, MaxYear, 12, 31, 0, 1'b1, outcome(0, 0, 0, CountLimit - 1, 1'b0));
    add_row(DateToCount, 1, 12, 31, 22'h3FFFFF, 1'b1, outcome(0, 0, 0, 364, 1'b0));
    add_row(DateToCount, 0, 1, 1, 0, 1'b1, bad);
    add_row(DateToCount, MaxYear + 1, 1, 1, 0, 1'b1, bad);
    add_row(DateToCount, 16383, 15, 31, 22'h3FFFFF, 1'b1, bad);
    add_row(DateToCount, 2024, 0, 10, 0, 1'b1, bad);
    add_row(DateToCount, 2024, 13, 1, 0, 1'b1, bad);
    add_row(DateToCount, 2024, 5, 0, 0, 1'b1, bad);
    add_row(DateToCount, 2023, 4, 31, 0, 1'b1, bad);
    add_row(DateToCount, 1900, 2, 29, 0, 1'b1, bad);
    add_row(DateToCount, 2001, 2, 29, 0, 1'b1, bad);
    add_row(DateToCount, 2000, 2, 30, 0, 1'b1, bad);
    add_row(DateToCount, 2000, 2, 29, 0, 1'b0, bad);
    add_row(DateToCount, 2004, 2, 29, 22'h3FFFFF, 1'b0, bad);
    add_row(DateToCount, 2000, 3, 1, 0, 1'b0, bad);
    // Some count requests carry junk in the date fields, which must be ignored.
    add_row(CountToDate, 16383, 15, 31, 0, 1'b1, outcome(1, 1, 1, 0, 1'b0));
    add_row(CountToDate, 0, 0, 0, CountLimit - 1, 1'b1, outcome(MaxYear, 12, 31, 0, 1'b0));
    add_row(CountToDate, 0, 0, 0, CountLimit, 1'b1, bad);
    add_row(CountToDate, 16383, 15, 31, 22'h3FFFFF, 1'b1, bad);
    add_row(CountToDate, 0, 0, 0, 146096, 1'b1, outcome(400, 12, 31, 0, 1'b0));
    add_row(CountToDate, 0, 0, 0, 36524, 1'b1, outcome(101, 1, 1, 0, 1'b0));
    add_row(CountToDate, 0, 0, 0, 1460, 1'b1, outcome(4, 12, 31, 0, 1'b0));
    add_row(CountToDate, 0, 0, 0, 365, 1'b1, outcome(2, 1, 1, 0, 1'b0));
    add_row(CountToDate, 0, 0, 0, 5 * 146097 - 1, 1'b0, bad);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[k]) begin
      pace();
      offer(stim_rows[k].rq, stim_rows[k].pin);
    end
    drain();

    for (i = 0; i < RandomItems; i++) begin
      if (i == ChokeAt) begin
        // Keep offering back to back while the response side holds off.
        choke_reqs <= choke_reqs + 1;
        burst_left = 160;
      end else if (i == PauseAt) begin
        drain();
      end
      pace();
      offer(random_request(), loose);
    end

    drain();
    repeat (DrainSlack) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/gdc_pkg.sv
rtl/gdc_if.sv
rtl/gregorian_date_day_count_converter.sv
rtl/gdc_checker.sv
verif/tb_top.sv
